/* hdl/dssm_pkg.sv */
// shared types, codes and constants for the dual stack shared memory block
`default_nettype none

package dssm_pkg;

   localparam int DEPTH_DEFAULT     = 32;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int FIELD_BITS        = 32;

   typedef enum logic [1:0] {
      OP_PUSH_A = 2'd0,
      OP_PUSH_B = 2'd1,
      OP_POP_A  = 2'd2,
      OP_POP_B  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_LOAD = 2'd2
   } state_type;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic signed [FIELD_BITS-1:0] push_value;
   } req_word_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] pop_value;
      logic [1:0]                   status;
      logic                         a_empty;
      logic                         b_empty;
      logic                         mem_full;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic take_req;
      logic execute;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

/* hdl/dual_stack_shared_memory.sv */
// top level of the dual stack shared memory block
//
// two lifo stacks share one memory of DEPTH words: stack a grows up from
// address 0, stack b grows down from address DEPTH-1
// request channel (req_valid, req_stall, req_word): one word carries an
// opcode (push a, push b, pop a, pop b) and a value to push
// response channel (rsp_valid, rsp_stall, rsp_word): exactly one word per
// request with the popped value, a status code and the empty and full flags
// as they stand after the operation
// a push into a full memory is refused with overflow; a pop of an empty
// stack returns all ones with underflow
// the controller walks accept, execute (pointer update and memory access)
// and response load; a receiver stall can hold the load, and a new request
// is accepted only after the previous one has been loaded
// the response sits in its own register, so a new request is accepted while
// the previous response still waits; while the receiver stalls, a finished
// result is held in the datapath while the controller waits for the register
// reset (synchronous, active high) empties both stacks and drops rsp_valid;
// memory contents are not cleared, as a word is only read after being pushed
`default_nettype none

module dual_stack_shared_memory #(
   parameter int DEPTH     = dssm_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = dssm_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire dssm_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output dssm_pkg::rsp_word_type      rsp_word
);

   // command and status between controller and datapath
   dssm_pkg::cmd_type  cmd;
   dssm_pkg::stat_type stat;

   dssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dssm_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

/* hdl/dssm_ctrl.sv */
// controller state machine for the dual stack shared memory block
`default_nettype none

module dssm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire dssm_pkg::stat_type stat,
   output dssm_pkg::cmd_type       cmd
);

   dssm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dssm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.take_req = 1'b0;
      cmd.execute  = 1'b0;
      cmd.load_rsp = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         dssm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = dssm_pkg::ST_EXEC;
            end
         end
         dssm_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = dssm_pkg::ST_LOAD;
         end
         dssm_pkg::ST_LOAD: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = dssm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dssm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/dssm_datapath.sv */
// counters, shared word memory and output register of the dual stack block
`default_nettype none

module dssm_datapath #(
   parameter int DEPTH     = dssm_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = dssm_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dssm_pkg::cmd_type      cmd,
   output dssm_pkg::stat_type          stat,
   input  wire dssm_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output dssm_pkg::rsp_word_type      rsp_word
);

   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int STORE_W = (WORD_BITS < dssm_pkg::FIELD_BITS) ? WORD_BITS
                                                               : dssm_pkg::FIELD_BITS;
   localparam int FB      = dssm_pkg::FIELD_BITS;

   logic [STORE_W-1:0] mem [DEPTH];
   logic [STORE_W-1:0] rd_data_ff;

   dssm_pkg::req_word_type item_ff;
   logic [CNT_W-1:0]       count_a_ff, count_a_in;
   logic [CNT_W-1:0]       count_b_ff, count_b_in;
   logic [1:0]             pend_status_ff, pend_status_in;
   logic                   pend_pop_ff, pend_pop_in;
   logic                   pend_a_empty_ff, pend_b_empty_ff, pend_full_ff;
   logic                   rsp_valid_ff;
   dssm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic [CNT_W:0]         used;
   logic [CNT_W:0]         used_in;
   logic                   full;
   logic                   wr_en, rd_en;
   logic [CNT_W-1:0]       addr_wide;
   logic [ADDR_W-1:0]      addr;
   logic [FB-1:0]          widened;

   assign used = {1'b0, count_a_ff} + {1'b0, count_b_ff};
   assign full = (used == (CNT_W + 1)'(DEPTH));

   always_comb begin
      count_a_in     = count_a_ff;
      count_b_in     = count_b_ff;
      pend_status_in = dssm_pkg::STATUS_OK;
      pend_pop_in    = 1'b0;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      addr_wide      = '0;
      case (dssm_pkg::opcode_type'(item_ff.opcode))
         dssm_pkg::OP_PUSH_A: begin
            addr_wide = count_a_ff;
            if (full) begin
               pend_status_in = dssm_pkg::STATUS_OVERFLOW;
            end else begin
               wr_en      = 1'b1;
               count_a_in = count_a_ff + 1'b1;
            end
         end
         dssm_pkg::OP_PUSH_B: begin
            addr_wide = CNT_W'(DEPTH - 1) - count_b_ff;
            if (full) begin
               pend_status_in = dssm_pkg::STATUS_OVERFLOW;
            end else begin
               wr_en      = 1'b1;
               count_b_in = count_b_ff + 1'b1;
            end
         end
         dssm_pkg::OP_POP_A: begin
            addr_wide = count_a_ff - 1'b1;
            if (count_a_ff == '0) begin
               pend_status_in = dssm_pkg::STATUS_UNDERFLOW;
            end else begin
               rd_en       = 1'b1;
               pend_pop_in = 1'b1;
               count_a_in  = count_a_ff - 1'b1;
            end
         end
         dssm_pkg::OP_POP_B: begin
            addr_wide = CNT_W'(DEPTH) - count_b_ff;
            if (count_b_ff == '0) begin
               pend_status_in = dssm_pkg::STATUS_UNDERFLOW;
            end else begin
               rd_en       = 1'b1;
               pend_pop_in = 1'b1;
               count_b_in  = count_b_ff - 1'b1;
            end
         end
         default: begin
            addr_wide = '0;
         end
      endcase
   end

   assign addr    = addr_wide[ADDR_W-1:0];
   assign used_in = {1'b0, count_a_in} + {1'b0, count_b_in};

   // shared word memory, one write or one registered read per item
   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) begin
         mem[addr] <= item_ff.push_value[STORE_W-1:0];
      end
      if (cmd.execute && rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         item_ff <= req_word;
      end
      if (cmd.execute) begin
         pend_status_ff  <= pend_status_in;
         pend_pop_ff     <= pend_pop_in;
         pend_a_empty_ff <= (count_a_in == '0);
         pend_b_empty_ff <= (count_b_in == '0);
         pend_full_ff    <= (used_in == (CNT_W + 1)'(DEPTH));
      end
      if (cmd.load_rsp) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.execute) begin
            count_a_ff <= count_a_in;
            count_b_ff <= count_b_in;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // sign extension of a stored word to the field width
   assign widened = FB'($signed(rd_data_ff));

   always_comb begin
      rsp_word_in.status   = pend_status_ff;
      rsp_word_in.a_empty  = pend_a_empty_ff;
      rsp_word_in.b_empty  = pend_b_empty_ff;
      rsp_word_in.mem_full = pend_full_ff;
      if (pend_status_ff == dssm_pkg::STATUS_UNDERFLOW) begin
         rsp_word_in.pop_value = '1;
      end else if (pend_pop_ff) begin
         rsp_word_in.pop_value = widened;
      end else begin
         rsp_word_in.pop_value = '0;
      end
   end

   assign stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word      = rsp_word_ff;

endmodule

`default_nettype wire
